@@ hw/rtl/lz77_token_decoder_defines.svh @@
// Assertion macros shared by the decoder RTL.
`ifndef LZ77_TOKEN_DECODER_DEFINES_SVH
`define LZ77_TOKEN_DECODER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LZ77TD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LZ77TD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/lz77td_pkg.sv @@
package lz77td_pkg;

    localparam int DIST_W = 12;
    localparam int LEN_W  = 4;
    localparam int BYTE_W = 8;

    localparam logic [LEN_W-1:0] LEN_MASK = 4'h0F;

endpackage

@@ hw/rtl/lz77td_token_if.sv @@
interface lz77td_token_if;

    logic                            valid;
    logic                            ready;
    logic [lz77td_pkg::DIST_W-1:0]   distance;
    logic [lz77td_pkg::LEN_W-1:0]    match_length;
    logic [lz77td_pkg::BYTE_W-1:0]   literal;

    modport source (output valid, output distance, output match_length, output literal,
                    input ready);
    modport sink   (input valid, input distance, input match_length, input literal,
                    output ready);

endinterface

@@ hw/rtl/lz77td_byte_if.sv @@
interface lz77td_byte_if;

    logic                            valid;
    logic                            ready;
    logic [lz77td_pkg::BYTE_W-1:0]   data_byte;
    logic                            last;
    logic                            bad_distance;

    modport source (output valid, output data_byte, output last, output bad_distance,
                    input ready);
    modport sink   (input valid, input data_byte, input last, input bad_distance,
                    output ready);

endinterface

@@ hw/rtl/lz77_token_decoder.sv @@
// A token is accepted only while the sequencer is idle; the next one waits until the current
// one is done. A token's first byte passes through the state register (literal-only token),
// or the state register and the RAM read register (token with a copy), into the output register.
// The copy moves one byte per cycle while the output is not stalled.
// Reset: write pointer, fill count, sequencer and output valid clear; the history RAM
// is not cleared, the fill count keeps unwritten entries from being read.
`include "lz77_token_decoder_defines.svh"

module lz77_token_decoder #(
    parameter int HISTORY_DEPTH = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lz77td_token_if.sink  i_tok,
    lz77td_byte_if.source o_byte
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [CW-1:0] FILL_MAX = CW'(HISTORY_DEPTH);
    localparam int LW = lz77td_pkg::LEN_W;
    localparam int BW = lz77td_pkg::BYTE_W;
    localparam int DW = lz77td_pkg::DIST_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COPY,
        ST_LIT
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_wp, n_wp;
    logic [CW-1:0]   r_fill, n_fill;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [LW-1:0]   r_reads_left, n_reads_left;
    logic            r_rd_pend, n_rd_pend;
    logic [BW-1:0]   r_lit, n_lit;
    logic            r_bad, n_bad;
    logic            r_out_valid, n_out_valid;
    logic [BW-1:0]   r_out_data, n_out_data;
    logic            r_out_last, n_out_last;
    logic            r_out_bad, n_out_bad;

    logic            tok_acc;
    logic            tok_bad;
    logic            tok_copy;
    logic [LW-1:0]   tok_len;
    logic [LW-1:0]   tok_n;
    logic            out_free;
    logic            load_copy;
    logic            load_lit;
    logic            rd_en;
    logic            wr_en;
    logic [BW-1:0]   wr_data;
    logic [BW-1:0]   rd_data;

    lz77td_ram #(
        .WIDTH (BW),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wp),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (rd_data)
    );

    assign i_tok.ready         = (r_state == ST_IDLE);
    assign o_byte.valid        = r_out_valid;
    assign o_byte.data_byte    = r_out_data;
    assign o_byte.last         = r_out_last;
    assign o_byte.bad_distance = r_out_bad;

    assign tok_acc  = i_tok.valid && i_tok.ready;
    assign tok_bad  = (i_tok.distance != '0) && (CW'(i_tok.distance) > r_fill);
    assign tok_copy = (i_tok.distance != '0) && !tok_bad;
    assign tok_len  = i_tok.match_length & lz77td_pkg::LEN_MASK;
    // cut the run to the distance so only older bytes are read
    assign tok_n    = !tok_copy ? '0 :
                      (DW'(tok_len) < i_tok.distance) ? tok_len : i_tok.distance[LW-1:0];

    assign out_free  = !r_out_valid || o_byte.ready;
    assign load_copy = (r_state == ST_COPY) && r_rd_pend && out_free;
    assign load_lit  = (r_state == ST_LIT) && out_free;
    assign rd_en     = (r_state == ST_COPY) && (r_reads_left != '0)
                       && (!r_rd_pend || load_copy);
    assign wr_en     = load_copy || load_lit;
    assign wr_data   = load_lit ? r_lit : rd_data;

    always_comb begin
        n_state      = r_state;
        n_wp         = r_wp;
        n_fill       = r_fill;
        n_rd_ptr     = r_rd_ptr;
        n_reads_left = r_reads_left;
        n_lit        = r_lit;
        n_bad        = r_bad;
        n_out_valid  = r_out_valid && !o_byte.ready;
        n_out_data   = r_out_data;
        n_out_last   = r_out_last;
        n_out_bad    = r_out_bad;
        n_rd_pend    = rd_en ? 1'b1 : (load_copy ? 1'b0 : r_rd_pend);

        // every emitted word also goes into history
        if (wr_en) begin
            n_out_valid = 1'b1;
            n_out_data  = wr_data;
            n_out_last  = load_lit;
            n_out_bad   = load_lit && r_bad;
            n_wp        = r_wp + 1'b1;
            if (r_fill != FILL_MAX) begin
                n_fill = r_fill + 1'b1;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (tok_acc) begin
                    n_rd_ptr     = r_wp - AW'(i_tok.distance);
                    n_reads_left = tok_n;
                    n_lit        = i_tok.literal;
                    n_bad        = tok_bad;
                    n_state      = (tok_n != '0) ? ST_COPY : ST_LIT;
                end
            end
            ST_COPY: begin
                if (rd_en) begin
                    n_rd_ptr     = r_rd_ptr + 1'b1;
                    n_reads_left = r_reads_left - 1'b1;
                end
                if ((r_reads_left == '0) && (!r_rd_pend || load_copy)) begin
                    n_state = ST_LIT;
                end
            end
            ST_LIT: begin
                if (load_lit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
        r_rd_ptr     <= n_rd_ptr;
        r_reads_left <= n_reads_left;
        r_lit        <= n_lit;
        r_bad        <= n_bad;
        r_out_data   <= n_out_data;
        r_out_last   <= n_out_last;
        r_out_bad    <= n_out_bad;
    end

    `LZ77TD_ASSERT_NEXT(a_rd_hold, i_clk, i_rst_n, r_rd_pend && !load_copy, r_rd_pend, "history read word dropped")
    `LZ77TD_ASSERT_SAME(a_fill_cap, i_clk, i_rst_n, 1'b1, r_fill <= FILL_MAX, "fill count past depth")
    `LZ77TD_ASSERT_NEXT(a_wr_out, i_clk, i_rst_n, wr_en, r_out_valid, "history write without output word")
    `LZ77TD_ASSERT_SAME(a_bad_lit, i_clk, i_rst_n, r_out_valid && r_out_bad, r_out_last, "bad distance on copied word")

endmodule

@@ hw/rtl/lz77td_ram.sv @@
module lz77td_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // read data holds until the next read
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
